@@ rtl/duplicate_request_cache_core_macros.svh @@
`ifndef DUPLICATE_REQUEST_CACHE_CORE_MACROS_SVH
`define DUPLICATE_REQUEST_CACHE_CORE_MACROS_SVH
// Same-cycle implication check.
`define DRC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");
// Next-cycle implication check.
`define DRC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");
`endif

@@ rtl/drc_pkg.sv @@
package drc_pkg;
   localparam int TABLE_DEPTH = 128;
   localparam int SLOT_W      = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = SLOT_W + 1;
   localparam logic [31:0] RETIRE_BIAS = 32'd16;

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_FINISH = 2'd1,
      ACT_DELETE = 2'd2,
      ACT_NONE   = 2'd3
   } drc_action_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EXISTS = 2'd1,
      ST_BUSY   = 2'd2,
      ST_FULL   = 2'd3
   } drc_status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_MATCH,
      FSM_ENCODE,
      FSM_DECIDE
   } drc_fsm_type;

   typedef enum logic [1:0] {
      CSR_SOFT     = 2'd0,
      CSR_HARD     = 2'd1,
      CSR_CHECKSUM = 2'd2,
      CSR_ADDRESS  = 2'd3
   } drc_csr_type;

   // Values shared by every cell of the row.
   typedef struct packed {
      logic [47:0]       client_addr;
      logic [31:0]       xid;
      logic [63:0]       checksum_hi;
      logic [63:0]       checksum_lo;
      logic [31:0]       tag;
      logic              use_checksum;
      logic              use_address;
      logic [SLOT_W-1:0] ins_age;
      logic              age_dec;
      logic [SLOT_W-1:0] rem_age;
   } drc_bcast_type;

   // Per-cell strobes.
   typedef struct packed {
      logic insert;
      logic finish;
      logic remove;
   } drc_sel_type;

   // Per-cell status.
   typedef struct packed {
      logic              valid;
      logic              done;
      logic              hit;
      logic              oldest;
      logic [SLOT_W-1:0] age;
      logic [31:0]       tag;
   } drc_stat_type;

   // Lowest set bit of a vector.
   function automatic logic [SLOT_W-1:0] first_set(input logic [TABLE_DEPTH-1:0] v);
      logic [SLOT_W-1:0] idx;
      idx = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (v[i]) idx = SLOT_W'(i);
      end
      return idx;
   endfunction
endpackage

@@ rtl/drc_if.sv @@
interface drc_req_if;
   import drc_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        action;
   logic [47:0]       client_addr;
   logic [31:0]       xid;
   logic [63:0]       checksum_hi;
   logic [63:0]       checksum_lo;
   logic [SLOT_W-1:0] slot;
   logic [31:0]       tag_in;
   modport source (output valid, action, client_addr, xid, checksum_hi, checksum_lo,
                   slot, tag_in, input ready);
   modport sink (input valid, action, client_addr, xid, checksum_hi, checksum_lo,
                 slot, tag_in, output ready);
endinterface

interface drc_rsp_if;
   import drc_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic [SLOT_W-1:0] slot_out;
   logic [31:0]       tag_out;
   logic              retired;
   logic [SLOT_W-1:0] retired_slot;
   modport source (output valid, status, slot_out, tag_out, retired, retired_slot,
                   input ready);
   modport sink (input valid, status, slot_out, tag_out, retired, retired_slot,
                 output ready);
endinterface

@@ rtl/drc_cell.sv @@
module drc_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  drc_pkg::drc_bcast_type bcast,
   input  drc_pkg::drc_sel_type   sel,
   output drc_pkg::drc_stat_type  stat
);
   import drc_pkg::*;

   logic              valid_ff, valid_in;
   logic              done_ff, done_in;
   logic [SLOT_W-1:0] age_ff, age_in;
   logic [47:0]       addr_ff;
   logic [31:0]       xid_ff;
   logic [63:0]       chk_hi_ff;
   logic [63:0]       chk_lo_ff;
   logic [31:0]       tag_ff;
   logic              key_eq;

   // Key compare against the broadcast request.
   always_comb begin
      key_eq = (xid_ff == bcast.xid);
      if (bcast.use_address && addr_ff != bcast.client_addr) key_eq = 1'b0;
      if (bcast.use_checksum &&
          (chk_hi_ff != bcast.checksum_hi || chk_lo_ff != bcast.checksum_lo)) key_eq = 1'b0;
   end

   // Next state of the control bits; removal wins over finish.
   always_comb begin
      valid_in = valid_ff;
      done_in  = done_ff;
      age_in   = age_ff;
      if (bcast.age_dec && valid_ff && age_ff > bcast.rem_age) age_in = age_ff - 1'b1;
      if (sel.insert) begin
         valid_in = 1'b1;
         done_in  = 1'b0;
         age_in   = bcast.ins_age;
      end
      if (sel.finish) done_in = 1'b1;
      if (sel.remove) begin
         valid_in = 1'b0;
         done_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         done_ff  <= done_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      age_ff <= age_in;
      if (sel.insert) begin
         addr_ff   <= bcast.client_addr;
         xid_ff    <= bcast.xid;
         chk_hi_ff <= bcast.checksum_hi;
         chk_lo_ff <= bcast.checksum_lo;
      end
      if (sel.finish) tag_ff <= bcast.tag;
   end

   assign stat.valid  = valid_ff;
   assign stat.done   = done_ff;
   assign stat.hit    = valid_ff && key_eq;
   assign stat.oldest = valid_ff && (age_ff == '0);
   assign stat.age    = age_ff;
   assign stat.tag    = tag_ff;
endmodule

@@ rtl/duplicate_request_cache_core.sv @@
// An accepted request passes the match, encode and decide states, one request at a time;
// the row of cells is compared, then the match vectors are priority encoded, then the
// table and age order are updated, and decide waits while a response is stalled.
// Reset (synchronous, active high) empties the table, clears the count and the
// retire window, and loads the register defaults; no clearing pass is needed.
module duplicate_request_cache_core (
   input  logic        clock,
   input  logic        reset,
   drc_req_if.sink     req_bus,
   drc_rsp_if.source   rsp_bus,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import drc_pkg::*;

   drc_fsm_type state_ff, state_in;

   logic [7:0]  soft_ff, hard_ff;
   logic        use_chk_ff, use_addr_ff;

   logic [1:0]        action_ff;
   logic [47:0]       addr_ff;
   logic [31:0]       xid_ff;
   logic [63:0]       chk_hi_ff, chk_lo_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [31:0]       tag_in_ff;

   logic [TABLE_DEPTH-1:0] hit_vec_ff, free_vec_ff, old_vec_ff;
   logic                   hit_any_ff, free_any_ff;
   logic [SLOT_W-1:0]      hit_idx_ff, free_idx_ff, old_idx_ff;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [31:0]        window_ff, window_in;

   logic              rsp_valid_ff;
   logic [1:0]        status_ff, status_in;
   logic [SLOT_W-1:0] slot_out_ff, slot_out_in;
   logic [31:0]       tag_out_ff, tag_out_in;
   logic              retired_ff, retired_in;
   logic [SLOT_W-1:0] rslot_ff, rslot_in;

   drc_bcast_type bcast;
   drc_sel_type   sel   [TABLE_DEPTH];
   drc_stat_type  stat  [TABLE_DEPTH];
   logic          req_take, decide_go, retire_now;

   // Row of cells.
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      drc_cell u_cell (.clock(clock), .reset(reset), .bcast(bcast), .sel(sel[g]),
                       .stat(stat[g]));
   end

   assign req_bus.ready = (state_ff == FSM_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign decide_go     = (state_ff == FSM_DECIDE) && (!rsp_valid_ff || rsp_bus.ready);

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) state_ff <= FSM_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE:   if (req_take) state_in = FSM_MATCH;
         FSM_MATCH:  state_in = FSM_ENCODE;
         FSM_ENCODE: state_in = FSM_DECIDE;
         FSM_DECIDE: if (decide_go) state_in = FSM_IDLE;
         default:    state_in = FSM_IDLE;
      endcase
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         soft_ff     <= 8'd127;
         hard_ff     <= 8'd128;
         use_chk_ff  <= 1'b1;
         use_addr_ff <= 1'b1;
      end else if (csr_we) begin
         unique case (drc_csr_type'(csr_index))
            CSR_SOFT:     soft_ff     <= csr_wdata;
            CSR_HARD:     hard_ff     <= csr_wdata;
            CSR_CHECKSUM: use_chk_ff  <= csr_wdata[0];
            CSR_ADDRESS:  use_addr_ff <= csr_wdata[0];
            default:      ;
         endcase
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (req_take) begin
         action_ff <= req_bus.action;
         addr_ff   <= req_bus.client_addr;
         xid_ff    <= req_bus.xid;
         chk_hi_ff <= req_bus.checksum_hi;
         chk_lo_ff <= req_bus.checksum_lo;
         slot_ff   <= req_bus.slot;
         tag_in_ff <= req_bus.tag_in;
      end
   end

   // Match vectors, then their priority encodes.
   always_ff @(posedge clock) begin
      if (state_ff == FSM_MATCH) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            hit_vec_ff[i]  <= stat[i].hit;
            free_vec_ff[i] <= !stat[i].valid;
            old_vec_ff[i]  <= stat[i].oldest;
         end
      end
      if (state_ff == FSM_ENCODE) begin
         hit_any_ff  <= |hit_vec_ff;
         free_any_ff <= |free_vec_ff;
         hit_idx_ff  <= first_set(hit_vec_ff);
         free_idx_ff <= first_set(free_vec_ff);
         old_idx_ff  <= first_set(old_vec_ff);
      end
   end

   // Decision and table update.
   always_comb begin
      bcast.client_addr  = addr_ff;
      bcast.xid          = xid_ff;
      bcast.checksum_hi  = chk_hi_ff;
      bcast.checksum_lo  = chk_lo_ff;
      bcast.tag          = tag_in_ff;
      bcast.use_checksum = use_chk_ff;
      bcast.use_address  = use_addr_ff;
      bcast.ins_age      = count_ff[SLOT_W-1:0];
      bcast.age_dec      = 1'b0;
      bcast.rem_age      = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) sel[i] = '0;
      count_in    = count_ff;
      window_in   = window_ff;
      status_in   = ST_OK;
      slot_out_in = '0;
      tag_out_in  = '0;
      retired_in  = 1'b0;
      rslot_in    = '0;
      retire_now  = ({1'b0, count_ff} > {1'b0, hard_ff}) ||
                    (window_ff == '0 && {1'b0, count_ff} > {1'b0, soft_ff});
      if (decide_go) begin
         case (drc_action_type'(action_ff))
            ACT_ADD: begin
               if (hit_any_ff) begin
                  slot_out_in = hit_idx_ff;
                  if (!stat[hit_idx_ff].done) begin
                     status_in = ST_BUSY;
                  end else begin
                     status_in  = ST_EXISTS;
                     tag_out_in = stat[hit_idx_ff].tag;
                     if (window_ff == '0)       window_in = RETIRE_BIAS;
                     else if (window_ff != '1)  window_in = window_ff + 32'd1;
                  end
               end else if (!free_any_ff) begin
                  status_in = ST_FULL;
               end else begin
                  sel[free_idx_ff].insert = 1'b1;
                  count_in    = count_ff + 1'b1;
                  slot_out_in = free_idx_ff;
               end
            end
            ACT_FINISH: begin
               if (stat[slot_ff].valid) begin
                  sel[slot_ff].finish = 1'b1;
                  if (retire_now) begin
                     sel[old_idx_ff].remove = 1'b1;
                     bcast.age_dec = 1'b1;
                     count_in      = count_ff - 1'b1;
                     retired_in    = 1'b1;
                     rslot_in      = old_idx_ff;
                  end
                  if (window_ff != '0) window_in = window_ff - 32'd1;
               end
            end
            ACT_DELETE: begin
               if (stat[slot_ff].valid) begin
                  sel[slot_ff].remove = 1'b1;
                  bcast.age_dec = 1'b1;
                  bcast.rem_age = stat[slot_ff].age;
                  count_in      = count_ff - 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         window_ff <= '0;
      end else begin
         count_ff  <= count_in;
         window_ff <= window_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset)                             rsp_valid_ff <= 1'b0;
      else if (decide_go)                    rsp_valid_ff <= 1'b1;
      else if (rsp_bus.ready)                rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (decide_go) begin
         status_ff   <= status_in;
         slot_out_ff <= slot_out_in;
         tag_out_ff  <= tag_out_in;
         retired_ff  <= retired_in;
         rslot_ff    <= rslot_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = status_ff;
   assign rsp_bus.slot_out     = slot_out_ff;
   assign rsp_bus.tag_out      = tag_out_ff;
   assign rsp_bus.retired      = retired_ff;
   assign rsp_bus.retired_slot = rslot_ff;
endmodule

@@ rtl/drc_checker.sv @@
`include "duplicate_request_cache_core_macros.svh"
module drc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] status,
   input logic [6:0] slot_out,
   input logic [31:0] tag_out,
   input logic       retired,
   input logic [6:0] retired_slot
);
   import drc_pkg::*;

   // The core takes one request at a time, so ready drops after an accept.
   `DRC_ASSERT_NXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)
   // A stalled response stays up.
   `DRC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // Only a finish retires, so a retire response carries success status.
   `DRC_ASSERT_IMP(a_retire_ok, clock, reset, rsp_valid && retired, status == ST_OK)
   // A stored tag only comes back on a completed hit.
   `DRC_ASSERT_IMP(a_tag_exists, clock, reset, rsp_valid && tag_out != '0,
                   status == ST_EXISTS)
   // A table-full response names no slot.
   `DRC_ASSERT_IMP(a_full_quiet, clock, reset, rsp_valid && status == ST_FULL,
                   slot_out == '0 && !retired && retired_slot == '0)
endmodule

bind duplicate_request_cache_core drc_checker u_drc_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_bus.valid), .req_ready(req_bus.ready),
   .rsp_valid(rsp_bus.valid), .rsp_ready(rsp_bus.ready),
   .status(rsp_bus.status), .slot_out(rsp_bus.slot_out), .tag_out(rsp_bus.tag_out),
   .retired(rsp_bus.retired), .retired_slot(rsp_bus.retired_slot)
);
